FILE: hw/rtl/tst_pkg.sv
// Shared types and constants for the TDMA slot timer.
package tst_pkg;

  // Default widths
  localparam int TIME_BITS_DEF = 20;
  localparam int GW_BITS_DEF   = 32;
  localparam int WDOG_BITS     = 22;
  localparam int SEND_BITS     = 32;
  localparam int PADDR_BITS    = 5;
  localparam int PDATA_BITS    = 32;

  // Register reset values
  localparam int CYCLE_RST = 18000;
  localparam int SLOT_START_RST = 12000;
  localparam int SLOT_LEN_RST = 6000;
  localparam int WAKE_LEAD_RST = 300;
  localparam int WDOG_RST = 54000;

  // Guard time added to the wake lead before a sleep is worth it
  localparam int GUARD_MS = 50;

  // Minimum effective cycle length
  localparam int MIN_CYCLE = 2;

  typedef enum logic [2:0] {
    REG_CYCLE_LENGTH     = 3'd0,
    REG_SLOT_START       = 3'd1,
    REG_SLOT_LENGTH      = 3'd2,
    REG_WAKE_LEAD        = 3'd3,
    REG_WATCHDOG_TIMEOUT = 3'd4
  } cfg_idx_t;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_SYNC = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_ADV,
    S_MOD_POS,
    S_MOD_GW,
    S_MOD_RAW,
    S_SYNC_OFS,
    S_EVAL,
    S_DECIDE,
    S_DONE
  } state_t;

  // Status of the shared remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

FILE: hw/rtl/tst_cfg_regs.sv
// Configuration register file behind the APB-style port.
module tst_cfg_regs #(
  parameter int TIME_BITS = tst_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tst_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [tst_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [tst_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready,
  output logic [TIME_BITS-1:0]            cycle_eff,
  output logic [TIME_BITS-1:0]            slot_start,
  output logic [TIME_BITS-1:0]            slot_length,
  output logic [TIME_BITS-1:0]            wake_lead,
  output logic [tst_pkg::WDOG_BITS-1:0]   watchdog_timeout
);
  import tst_pkg::*;

  logic [TIME_BITS-1:0] cycle_r, start_r, len_r, margin_r;
  logic [WDOG_BITS-1:0] wdog_r;
  logic                 wr_en;
  cfg_idx_t             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = cfg_idx_t'(paddr[PADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_r  <= TIME_BITS'(CYCLE_RST);
      start_r  <= TIME_BITS'(SLOT_START_RST);
      len_r    <= TIME_BITS'(SLOT_LEN_RST);
      margin_r <= TIME_BITS'(WAKE_LEAD_RST);
      wdog_r   <= WDOG_BITS'(WDOG_RST);
    end else if (wr_en) begin
      unique case (idx)
        REG_CYCLE_LENGTH:     cycle_r  <= pwdata[TIME_BITS-1:0];
        REG_SLOT_START:       start_r  <= pwdata[TIME_BITS-1:0];
        REG_SLOT_LENGTH:      len_r    <= pwdata[TIME_BITS-1:0];
        REG_WAKE_LEAD:        margin_r <= pwdata[TIME_BITS-1:0];
        REG_WATCHDOG_TIMEOUT: wdog_r   <= pwdata[WDOG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CYCLE_LENGTH:     prdata = PDATA_BITS'(cycle_r);
      REG_SLOT_START:       prdata = PDATA_BITS'(start_r);
      REG_SLOT_LENGTH:      prdata = PDATA_BITS'(len_r);
      REG_WAKE_LEAD:        prdata = PDATA_BITS'(margin_r);
      REG_WATCHDOG_TIMEOUT: prdata = PDATA_BITS'(wdog_r);
      default:              prdata = '0;
    endcase
  end

  // Clamp short cycles to the minimum
  assign cycle_eff        = (cycle_r < TIME_BITS'(MIN_CYCLE)) ? TIME_BITS'(MIN_CYCLE) : cycle_r;
  assign slot_start       = start_r;
  assign slot_length      = len_r;
  assign wake_lead        = margin_r;
  assign watchdog_timeout = wdog_r;

endmodule

FILE: hw/rtl/tst_mod_unit.sv
// Shared restoring remainder unit, one dividend bit per cycle.
module tst_mod_unit #(
  parameter int TIME_BITS = tst_pkg::TIME_BITS_DEF,
  parameter int DVD_BITS  = tst_pkg::GW_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_BITS-1:0]  dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output logic [TIME_BITS-1:0] remainder,
  output tst_pkg::mod_stat_t   stat
);
  import tst_pkg::*;

  localparam int CW = $clog2(DVD_BITS + 1);

  logic [DVD_BITS-1:0]  dvd_r, dvd_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   trial_sub;

  // Shift in the next dividend bit, subtract when it fits
  assign trial     = {rem_r, dvd_r[DVD_BITS-1]};
  assign trial_sub = trial - {1'b0, divisor};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == CW'(1));
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DVD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_BITS-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hw/rtl/tdma_slot_timer_with_sync_core.sv
// Top level of the TDMA slot timer: sequencer, timing state and result register.
//
// One transaction on the input channel is either a one-millisecond tick or a sync
// carrying the gateway clock, and each gives exactly one result transaction. All
// reductions modulo the cycle length run on one shared restoring remainder unit that
// retires one dividend bit per cycle over DW = max(GATEWAY_TIME_BITS, TIME_BITS+2)
// bits; the sequencer steps it and the block holds in_stall high until the item has
// finished. A tick advances the raw counter and then needs one remainder, and a sync
// needs two remainders, one of the gateway time and one of the raw count. A new
// item is taken as soon as the sequencer is back in idle, even while the previous
// result still waits in the output register. Configuration is written through the
// APB-style port at byte address 4*i and should only change while the block is idle;
// a cycle length below 2 acts as 2. The watchdog flag is status only and stays up on
// every tick until the next transmit.
module tdma_slot_timer_with_sync_core #(
  parameter int TIME_BITS         = tst_pkg::TIME_BITS_DEF,
  parameter int GATEWAY_TIME_BITS = tst_pkg::GW_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [GATEWAY_TIME_BITS-1:0]         in_gateway_time,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [TIME_BITS-1:0]                 out_cycle_position,
  output logic                                 out_in_slot,
  output logic                                 out_transmit_now,
  output logic                                 out_heater_was_cold,
  output logic                                 out_watchdog_expired,
  output logic                                 out_sleep_request,
  output logic [TIME_BITS-1:0]                 out_sleep_length,
  output logic                                 out_heater_active,
  output logic signed [TIME_BITS:0]            out_offset_now,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tst_pkg::PADDR_BITS-1:0]       paddr,
  input  logic [tst_pkg::PDATA_BITS-1:0]       pwdata,
  output logic [tst_pkg::PDATA_BITS-1:0]       prdata,
  output logic                                 pready
);
  import tst_pkg::*;

  // Dividend width of the shared unit: gateway time or |raw + offset|
  localparam int DW = (GATEWAY_TIME_BITS > TIME_BITS + 2) ? GATEWAY_TIME_BITS : TIME_BITS + 2;
  localparam int TB = TIME_BITS;

  // Configuration
  logic [TB-1:0]        cl;
  logic [TB-1:0]        slot_start;
  logic [TB-1:0]        slot_length;
  logic [TB-1:0]        wake_lead;
  logic [WDOG_BITS-1:0] wdog_timeout;

  tst_cfg_regs #(
    .TIME_BITS (TIME_BITS)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .cycle_eff        (cl),
    .slot_start       (slot_start),
    .slot_length      (slot_length),
    .wake_lead        (wake_lead),
    .watchdog_timeout (wdog_timeout)
  );

  // Shared remainder unit
  logic          mod_start;
  logic [DW-1:0] mod_dividend;
  logic [TB-1:0] mod_rem;
  mod_stat_t     mod_stat;

  tst_mod_unit #(
    .TIME_BITS (TIME_BITS),
    .DVD_BITS  (DW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (cl),
    .remainder (mod_rem),
    .stat      (mod_stat)
  );

  // Sequencer
  state_t state_r, state_nxt;
  logic   first_r, first_nxt;    // first cycle in a state: kick the remainder unit
  logic   in_accept;

  // Timing state
  logic [TB-1:0]           raw_r, raw_nxt;
  logic signed [TB:0]      ofs_r, ofs_nxt;
  logic [SEND_BITS-1:0]    tss_r, tss_nxt;
  logic                    sent_r, sent_nxt;
  logic                    heat_r, heat_nxt;

  // Per-item working registers
  op_t                     op_r, op_nxt;
  logic [GATEWAY_TIME_BITS-1:0] gw_r, gw_nxt;
  logic [TB-1:0]           gp_r, gp_nxt;
  logic [TB-1:0]           mp_r, mp_nxt;
  logic [TB-1:0]           pos_r, pos_nxt;
  logic                    inside_r, inside_nxt;
  logic [TB:0]             dist_r, dist_nxt;
  logic                    wd_r, wd_nxt;
  logic                    txok_r, txok_nxt;
  logic                    tx_r, tx_nxt;
  logic                    cold_r, cold_nxt;
  logic                    sreq_r, sreq_nxt;
  logic [TB-1:0]           slen_r, slen_nxt;

  // Result register
  logic                    ovld_r, ovld_nxt;
  logic [TB-1:0]           opos_r, opos_nxt;
  logic                    oslot_r, oslot_nxt;
  logic                    otx_r, otx_nxt;
  logic                    ocold_r, ocold_nxt;
  logic                    owd_r, owd_nxt;
  logic                    osreq_r, osreq_nxt;
  logic [TB-1:0]           oslen_r, oslen_nxt;
  logic                    oheat_r, oheat_nxt;
  logic signed [TB:0]      oofs_r, oofs_nxt;

  // Datapath helpers
  logic signed [TB+1:0]    pos_sum;     // raw + offset, before reduction
  logic                    sum_neg;
  logic [TB+1:0]           sum_abs;
  logic [TB:0]             raw_inc;
  logic signed [TB+1:0]    diff;
  logic signed [TB+1:0]    diff_dn;     // phase error minus one cycle
  logic signed [TB+1:0]    diff_up;     // phase error plus one cycle
  logic signed [TB+1:0]    half;
  logic signed [TB+1:0]    cl_s;
  logic [TB:0]             slot_end;
  logic [TB:0]             wake_guard;
  logic [TB:0]             sleep_raw;
  logic                    out_free;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !ovld_r || !out_stall;

  assign pos_sum = $signed({2'b00, raw_r}) + $signed({ofs_r[TB], ofs_r});
  assign sum_neg = pos_sum[TB+1];
  assign sum_abs = sum_neg ? (TB+2)'(-pos_sum) : pos_sum;
  assign raw_inc = {1'b0, raw_r} + (TB+1)'(1);
  assign cl_s    = $signed({2'b00, cl});
  assign half    = $signed({3'b000, cl[TB-1:1]});
  assign diff    = $signed({2'b00, gp_r}) - $signed({2'b00, mp_r});
  assign diff_dn = diff - cl_s;
  assign diff_up = diff + cl_s;
  assign slot_end   = {1'b0, slot_start} + {1'b0, slot_length};
  assign wake_guard = {1'b0, wake_lead} + (TB+1)'(GUARD_MS);
  assign sleep_raw  = dist_r - {1'b0, wake_lead};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (op_t'(in_operation) == OP_SYNC) ? S_MOD_GW : S_TICK_ADV;
        end
      end
      S_TICK_ADV: state_nxt = S_MOD_POS;
      S_MOD_POS: begin
        if (mod_stat.done) begin
          state_nxt = S_EVAL;
        end
      end
      S_MOD_GW: begin
        if (mod_stat.done) begin
          state_nxt = S_MOD_RAW;
        end
      end
      S_MOD_RAW: begin
        if (mod_stat.done) begin
          state_nxt = S_SYNC_OFS;
        end
      end
      S_SYNC_OFS: state_nxt = S_EVAL;
      S_EVAL:     state_nxt = S_DECIDE;
      S_DECIDE:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign first_nxt = (state_nxt != state_r);

  // Sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    mod_start    = 1'b0;
    mod_dividend = '0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_MOD_POS: begin
        mod_start    = first_r;
        mod_dividend = DW'(sum_abs);
      end
      S_MOD_GW: begin
        mod_start    = first_r;
        mod_dividend = DW'(gw_r);
      end
      S_MOD_RAW: begin
        mod_start    = first_r;
        mod_dividend = DW'(raw_r);
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    raw_nxt    = raw_r;
    ofs_nxt    = ofs_r;
    tss_nxt    = tss_r;
    sent_nxt   = sent_r;
    heat_nxt   = heat_r;
    op_nxt     = op_r;
    gw_nxt     = gw_r;
    gp_nxt     = gp_r;
    mp_nxt     = mp_r;
    pos_nxt    = pos_r;
    inside_nxt = inside_r;
    dist_nxt   = dist_r;
    wd_nxt     = wd_r;
    txok_nxt   = txok_r;
    tx_nxt     = tx_r;
    cold_nxt   = cold_r;
    sreq_nxt   = sreq_r;
    slen_nxt   = slen_r;
    ovld_nxt   = ovld_r;
    opos_nxt   = opos_r;
    oslot_nxt  = oslot_r;
    otx_nxt    = otx_r;
    ocold_nxt  = ocold_r;
    owd_nxt    = owd_r;
    osreq_nxt  = osreq_r;
    oslen_nxt  = oslen_r;
    oheat_nxt  = oheat_r;
    oofs_nxt   = oofs_r;

    // Drop the result once it is taken
    if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt = op_t'(in_operation);
          gw_nxt = in_gateway_time;
        end
      end
      S_TICK_ADV: begin
        // Advance the raw counter, wrap at the cycle; saturate time since send
        raw_nxt = (raw_inc >= {1'b0, cl}) ? '0 : raw_inc[TB-1:0];
        if (~&tss_r) begin
          tss_nxt = tss_r + SEND_BITS'(1);
        end
      end
      S_MOD_POS: begin
        // Fold a negative sum back into the cycle
        if (mod_stat.done) begin
          pos_nxt = (sum_neg && (mod_rem != '0)) ? (cl - mod_rem) : mod_rem;
        end
      end
      S_MOD_GW: begin
        if (mod_stat.done) begin
          gp_nxt = mod_rem;
        end
      end
      S_MOD_RAW: begin
        if (mod_stat.done) begin
          mp_nxt = mod_rem;
        end
      end
      S_SYNC_OFS: begin
        // Wrap the phase error into plus or minus half a cycle
        priority if (diff > half) begin
          ofs_nxt = diff_dn[TB:0];
        end else if (diff < -half) begin
          ofs_nxt = diff_up[TB:0];
        end else begin
          ofs_nxt = diff[TB:0];
        end
        // raw + new offset lands on the gateway phase
        pos_nxt = gp_r;
      end
      S_EVAL: begin
        inside_nxt = ({1'b0, pos_r} >= {1'b0, slot_start}) && ({1'b0, pos_r} < slot_end);
        dist_nxt   = (pos_r < slot_start) ? ({1'b0, slot_start} - {1'b0, pos_r})
                                          : ({1'b0, cl} - {1'b0, pos_r} + {1'b0, slot_start});
        wd_nxt     = (op_r == OP_TICK) && sent_r && (tss_r > SEND_BITS'(wdog_timeout));
        txok_nxt   = tss_r >= SEND_BITS'(cl);
      end
      S_DECIDE: begin
        tx_nxt   = 1'b0;
        cold_nxt = 1'b0;
        sreq_nxt = 1'b0;
        slen_nxt = '0;
        if (op_r == OP_TICK) begin
          if (inside_r) begin
            if (txok_r) begin
              tx_nxt   = 1'b1;
              cold_nxt = !heat_r;
              tss_nxt  = '0;
              sent_nxt = 1'b1;
              heat_nxt = 1'b0;
            end
          end else begin
            // Too close to the slot to sleep: preheat; otherwise sleep, heater on after
            heat_nxt = 1'b1;
            if (dist_r > wake_guard) begin
              sreq_nxt = 1'b1;
              slen_nxt = sleep_raw[TB] ? {TB{1'b1}} : sleep_raw[TB-1:0];
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          opos_nxt  = pos_r;
          oslot_nxt = inside_r;
          otx_nxt   = tx_r;
          ocold_nxt = cold_r;
          owd_nxt   = wd_r;
          osreq_nxt = sreq_r;
          oslen_nxt = slen_r;
          oheat_nxt = heat_r;
          oofs_nxt  = ofs_r;
        end
      end
      default: ;
    endcase
  end

  // Control and timing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
      ovld_r  <= 1'b0;
      raw_r   <= '0;
      ofs_r   <= '0;
      tss_r   <= '0;
      sent_r  <= 1'b0;
      heat_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      ovld_r  <= ovld_nxt;
      raw_r   <= raw_nxt;
      ofs_r   <= ofs_nxt;
      tss_r   <= tss_nxt;
      sent_r  <= sent_nxt;
      heat_r  <= heat_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    gw_r     <= gw_nxt;
    gp_r     <= gp_nxt;
    mp_r     <= mp_nxt;
    pos_r    <= pos_nxt;
    inside_r <= inside_nxt;
    dist_r   <= dist_nxt;
    wd_r     <= wd_nxt;
    txok_r   <= txok_nxt;
    tx_r     <= tx_nxt;
    cold_r   <= cold_nxt;
    sreq_r   <= sreq_nxt;
    slen_r   <= slen_nxt;
    opos_r   <= opos_nxt;
    oslot_r  <= oslot_nxt;
    otx_r    <= otx_nxt;
    ocold_r  <= ocold_nxt;
    owd_r    <= owd_nxt;
    osreq_r  <= osreq_nxt;
    oslen_r  <= oslen_nxt;
    oheat_r  <= oheat_nxt;
    oofs_r   <= oofs_nxt;
  end

  assign out_valid            = ovld_r;
  assign out_cycle_position   = opos_r;
  assign out_in_slot          = oslot_r;
  assign out_transmit_now     = otx_r;
  assign out_heater_was_cold  = ocold_r;
  assign out_watchdog_expired = owd_r;
  assign out_sleep_request    = osreq_r;
  assign out_sleep_length     = oslen_r;
  assign out_heater_active    = oheat_r;
  assign out_offset_now       = oofs_r;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the TDMA slot timer: directed table, then randomized phases.
module tb_top;
  import tst_pkg::*;

  localparam int TB    = TIME_BITS_DEF;
  localparam int GWB   = GW_BITS_DEF;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT = 3000;  // cycles without any transaction
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 36;
  localparam int DRAIN_CYCLES = 100;  // longer than a sync takes to finish
  localparam longint TIME_MAX = (longint'(1) << TB) - 1;
  localparam longint SEND_MAX = (longint'(1) << SEND_BITS) - 1;

  // One result transaction, field for field as the ports carry it
  typedef struct packed {
    logic [TB-1:0]        cycle_position;
    logic                 in_slot;
    logic                 transmit_now;
    logic                 heater_was_cold;
    logic                 watchdog_expired;
    logic                 sleep_request;
    logic [TB-1:0]        sleep_length;
    logic                 heater_active;
    logic signed [TB:0]   offset_now;
  } timer_result_t;

  // One row of the directed table: a register write or an input transaction
  typedef struct {
    bit            is_write;
    cfg_idx_t      reg_idx;
    logic [31:0]   wdata;
    op_t           op;
    logic [GWB-1:0] gw;
    bit            typed;
    timer_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           in_operation = 1'b0;
  logic [GWB-1:0] in_gateway_time = '0;

  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [TB-1:0]  out_cycle_position;
  logic           out_in_slot;
  logic           out_transmit_now;
  logic           out_heater_was_cold;
  logic           out_watchdog_expired;
  logic           out_sleep_request;
  logic [TB-1:0]  out_sleep_length;
  logic           out_heater_active;
  logic signed [TB:0] out_offset_now;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  tdma_slot_timer_with_sync_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_gateway_time     (in_gateway_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cycle_position  (out_cycle_position),
    .out_in_slot         (out_in_slot),
    .out_transmit_now    (out_transmit_now),
    .out_heater_was_cold (out_heater_was_cold),
    .out_watchdog_expired(out_watchdog_expired),
    .out_sleep_request   (out_sleep_request),
    .out_sleep_length    (out_sleep_length),
    .out_heater_active   (out_heater_active),
    .out_offset_now      (out_offset_now),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the timer: configuration and timing state
  // ---------------------------------------------------------------------------
  logic [TB-1:0]        cycle_len_reg  = TB'(CYCLE_RST);
  logic [TB-1:0]        slot_start_reg = TB'(SLOT_START_RST);
  logic [TB-1:0]        slot_len_reg   = TB'(SLOT_LEN_RST);
  logic [TB-1:0]        wake_reg       = TB'(WAKE_LEAD_RST);
  logic [WDOG_BITS-1:0] wdog_reg       = WDOG_BITS'(WDOG_RST);

  longint raw_ms     = 0;
  longint offset_ms  = 0;
  longint since_send = 0;
  bit     sent_once  = 1'b0;
  bit     heater_on  = 1'b0;

  timer_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int            mismatches = 0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  // Advance the shadow timer by one input transaction and return its result.
  function automatic timer_result_t next_timer_result(op_t op, logic [GWB-1:0] gw);
    timer_result_t r;
    longint cl, pos, diff, gap, gw_ms, ss, sl, wm, wd;
    bit in_window;
    r = '0;
    gw_ms = gw;
    ss = slot_start_reg;
    sl = slot_len_reg;
    wm = wake_reg;
    wd = wdog_reg;
    // a cycle below the minimum behaves as the minimum
    cl = cycle_len_reg;
    if (cl < MIN_CYCLE) cl = MIN_CYCLE;
    if (op == OP_SYNC) begin
      // gateway position minus our own, folded into half a cycle each way
      diff = gw_ms % cl - raw_ms % cl;
      if (diff > cl / 2) diff -= cl;
      if (diff < -(cl / 2)) diff += cl;
      offset_ms = diff;
    end else begin
      // a raw count left beyond a shrunk cycle wraps on the next tick
      raw_ms = (raw_ms + 1 >= cl) ? 0 : raw_ms + 1;
      if (since_send < SEND_MAX) since_send++;
    end
    pos = (raw_ms % cl + offset_ms) % cl;
    if (pos < 0) pos += cl;
    in_window = pos >= ss && pos < ss + sl;
    if (op == OP_TICK) begin
      r.watchdog_expired = sent_once && since_send > wd;
      if (in_window) begin
        if (since_send >= cl) begin
          r.transmit_now    = 1'b1;
          r.heater_was_cold = !heater_on;
          since_send = 0;
          sent_once  = 1'b1;
          heater_on  = 1'b0;
        end
      end else begin
        // forward distance to the slot, wrapping through the cycle end
        gap = (pos < ss) ? ss - pos : cl - pos + ss;
        heater_on = 1'b1;
        if (gap > wm + GUARD_MS) begin
          gap -= wm;
          r.sleep_request = 1'b1;
          r.sleep_length  = TB'((gap > TIME_MAX) ? TIME_MAX : gap);
        end
      end
    end
    r.cycle_position = TB'(pos);
    r.in_slot        = in_window;
    r.heater_active  = heater_on;
    r.offset_now     = (TB+1)'(offset_ms);
    return r;
  endfunction

  function automatic void add_write(cfg_idx_t idx, logic [31:0] data);
    stim_row_t row;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.wdata    = data;
    row.op       = OP_TICK;
    row.gw       = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_item(op_t op, logic [GWB-1:0] gw, bit typed = 1'b0,
                                   timer_result_t want = '0);
    stim_row_t row;
    row.is_write = 1'b0;
    row.reg_idx  = REG_CYCLE_LENGTH;
    row.wdata    = '0;
    row.op       = op;
    row.gw       = gw;
    row.typed    = typed;
    row.want     = want;
    directed_rows.push_back(row);
  endfunction

  // Put random junk above a register's width half of the time; the block must drop it.
  function automatic logic [31:0] with_noise(int unsigned value, int width);
    logic [31:0] upper;
    upper = $urandom() & ~((32'd1 << width) - 1);
    return ($urandom_range(1) != 0 ? upper : 32'd0) | value;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one transaction, holding the payload until the block takes it.
  // Valid is only lowered for an idle gap or a drain, so back-to-back items keep it high.
  task automatic offer_item(input op_t op, input logic [GWB-1:0] gw,
                            input bit typed, input timer_result_t want);
    timer_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_gateway_time <= gw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = next_timer_result(op, gw);
    pending_results.push_back(typed ? want : r);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Two-phase register write; the register takes the value at the access edge.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CYCLE_LENGTH:     cycle_len_reg  = data[TB-1:0];
      REG_SLOT_START:       slot_start_reg = data[TB-1:0];
      REG_SLOT_LENGTH:      slot_len_reg   = data[TB-1:0];
      REG_WAKE_LEAD:        wake_reg       = data[TB-1:0];
      REG_WATCHDOG_TIMEOUT: wdog_reg       = data[WDOG_BITS-1:0];
      default: ;
    endcase
    // hold the bus idle before the next transfer
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall, plus a long hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{cycle_position: out_cycle_position, in_slot: out_in_slot,
              transmit_now: out_transmit_now, heater_was_cold: out_heater_was_cold,
              watchdog_expired: out_watchdog_expired, sleep_request: out_sleep_request,
              sleep_length: out_sleep_length, heater_active: out_heater_active,
              offset_now: out_offset_now};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: pos=%0d ofs=%0d",
                   got.cycle_position, got.offset_now);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch exp: pos=%0d slot=%0b tx=%0b cold=%0b wd=%0b",
                   want.cycle_position, want.in_slot, want.transmit_now,
                   want.heater_was_cold, want.watchdog_expired);
            $display(" sleep=%0b/%0d heat=%0b ofs=%0d",
                     want.sleep_request, want.sleep_length, want.heater_active,
                     want.offset_now);
            $write("         got: pos=%0d slot=%0b tx=%0b cold=%0b wd=%0b",
                   got.cycle_position, got.in_slot, got.transmit_now,
                   got.heater_was_cold, got.watchdog_expired);
            $display(" sleep=%0b/%0d heat=%0b ofs=%0d",
                     got.sleep_request, got.sleep_length, got.heater_active,
                     got.offset_now);
          end
        end
      end
    end
  end

  // Abort when no transaction of any kind has moved for too long.
  initial begin : quiet_watch
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned cl, ce, ss, sl, wm, wd, phase, n;
    op_t op;
    logic [GWB-1:0] gw;

    // Defaults after reset: first tick sits before the slot and sleeps toward it;
    // a sync to zero pulls the offset back by one.
    add_item(OP_TICK, '0, 1'b1,
             '{cycle_position: 20'd1, in_slot: 1'b0, transmit_now: 1'b0,
               heater_was_cold: 1'b0, watchdog_expired: 1'b0, sleep_request: 1'b1,
               sleep_length: 20'd11699, heater_active: 1'b1, offset_now: 21'sd0});
    add_item(OP_SYNC, '0, 1'b1,
             '{cycle_position: 20'd0, in_slot: 1'b0, transmit_now: 1'b0,
               heater_was_cold: 1'b0, watchdog_expired: 1'b0, sleep_request: 1'b0,
               sleep_length: 20'd0, heater_active: 1'b1, offset_now: -21'sd1});
    add_item(OP_SYNC, '1);
    add_item(OP_SYNC, 32'd9002);          // just past half a cycle: fold negative
    add_item(OP_TICK, '0);

    // Shrink the cycle below the minimum: raw count and offset now exceed it.
    // Tiny slot and zero timeout give transmits and watchdog expiry quickly.
    add_write(REG_SLOT_START, 32'd1);
    add_write(REG_SLOT_LENGTH, 32'd1);
    add_write(REG_WAKE_LEAD, 32'd0);
    add_write(REG_WATCHDOG_TIMEOUT, 32'd0);
    add_write(REG_CYCLE_LENGTH, 32'd0);
    repeat (6) add_item(OP_TICK, '0);
    add_item(OP_SYNC, 32'd1);
    add_item(OP_TICK, '0);

    // Widest cycle with the slot at its very end: long sleeps, masked upper bits.
    add_write(REG_CYCLE_LENGTH, 32'hFFFF_FFFF);
    add_write(REG_SLOT_START, 32'h000F_FFFE);
    add_write(REG_SLOT_LENGTH, 32'hFFF0_0001);
    add_write(REG_WAKE_LEAD, 32'hFFF0_0000);
    add_write(REG_WATCHDOG_TIMEOUT, 32'hFFFF_FFFF);
    add_item(OP_TICK, '0);
    add_item(OP_SYNC, '1);
    add_item(OP_TICK, '0);
    add_item(OP_SYNC, '0);
    add_item(OP_TICK, '0);

    // Cycle 1 (runs as 2), whole-cycle slot: after the first send heater off, sends cold.
    add_write(REG_CYCLE_LENGTH, 32'd1);
    add_write(REG_SLOT_START, 32'd0);
    add_write(REG_SLOT_LENGTH, 32'h000F_FFFF);
    add_write(REG_WAKE_LEAD, 32'h000F_FFFF);
    add_write(REG_WATCHDOG_TIMEOUT, 32'd0);
    add_item(OP_TICK, '0);
    add_item(OP_TICK, '0);
    add_item(OP_SYNC, 32'hAAAA_5555);
    add_item(OP_TICK, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
      end else begin
        offer_item(directed_rows[i].op, directed_rows[i].gw,
                   directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: fresh settings each time, mostly short cycles so that
    // sends, watchdog expiry and sleep decisions come up often.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      n = $urandom_range(9);
      if (n < 7)      cl = $urandom_range(48);
      else if (n < 9) cl = $urandom_range(3000, 49);
      else            cl = $urandom_range(TIME_MAX, 3000);
      ce = (cl < MIN_CYCLE) ? MIN_CYCLE : cl;
      ss = ($urandom_range(7) == 0) ? $urandom_range(TIME_MAX) : $urandom_range(ce - 1);
      sl = $urandom_range(ce, 1);
      wm = $urandom_range(ce);
      wd = ($urandom_range(3) == 0) ? $urandom_range((1 << WDOG_BITS) - 1)
                                    : $urandom_range(3 * ce);
      write_reg(REG_CYCLE_LENGTH, with_noise(cl, TB));
      write_reg(REG_SLOT_START, with_noise(ss, TB));
      write_reg(REG_SLOT_LENGTH, with_noise(sl, TB));
      write_reg(REG_WAKE_LEAD, with_noise(wm, TB));
      write_reg(REG_WATCHDOG_TIMEOUT, with_noise(wd, WDOG_BITS));

      // rotate through no idling, idle sender, stalling receiver, both
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 72; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 72; end
        default: begin send_idle_pct = 25; stall_pct <= 25; end
      endcase
      // hold the receiver off while items keep coming, so the block backs up
      if (phase == 4) begin
        send_idle_pct = 0;
        holds_asked <= holds_asked + 1;
      end

      repeat (PHASE_ITEMS) begin
        op = ($urandom_range(5) == 0) ? OP_SYNC : OP_TICK;
        gw = ($urandom_range(1) != 0) ? GWB'($urandom()) : GWB'($urandom_range(4 * ce));
        offer_item(op, gw, 1'b0, '0);
      end
    end

    // Wait out the tail and allow time for any stray result to show up.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
